/* design/jam_pkg.sv */
// shared types and constants of the joystick axis moving-average block
package jam_pkg;

	localparam int unsigned AXES           = 4;
	localparam int unsigned SAMPLE_W       = 12;
	localparam int unsigned MASK_W         = 4;
	localparam int unsigned WINDOW_DEFAULT = 8;
	localparam int unsigned MID_DEPTH      = 2;
	localparam int unsigned OUT_DEPTH      = 4;
	localparam int unsigned OUT_CNT_W      = $clog2(OUT_DEPTH + 1);

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef sample_t [AXES-1:0] axis_vec_t;
	typedef logic [MASK_W-1:0] mask_t;

	// msb first, so a cast to axis_vec_t puts left x at index 0
	typedef struct packed {
		sample_t right_y_sample;
		sample_t right_x_sample;
		sample_t left_y_sample;
		sample_t left_x_sample;
	} in_item_t;

	typedef struct packed {
		sample_t right_y_average;
		sample_t right_x_average;
		sample_t left_y_average;
		sample_t left_x_average;
	} out_item_t;

	localparam int unsigned ITEM_W = $bits(in_item_t);

	// queue status seen by the side that writes it
	typedef struct packed {
		logic                 empty;
		logic [OUT_CNT_W-1:0] count;
	} out_status_t;

endpackage

/* design/joystick_axis_moving_average_core.sv */
// top level of the joystick axis moving-average block
// usage:
// - input side is a queue: drive samples and raise push; a request is taken at a
//   rising edge with push high and full low. one sample set per cycle sustained while full stays low
// - result side is a queue: while empty is low the oldest result is on result;
//   it is taken at a rising edge with pop high
// - cfg channel writes invert_mask (valid/ready, ready always high); write it
//   only while no request is in flight
// - a result comes out only when some axis average changed since the last one
//   sent; otherwise the request produces nothing
// - path: a request goes through the intake queue, the ring read and running sum,
//   and the reciprocal multiply and compare before its result is queued
// - throughput: one request per cycle while the result queue keeps a free slot, set by the
//   sample ring, which takes one read and one write each cycle, the read in the cycle before its write
// - reset clears the ring (through per-entry valid bits), sums, ring index,
//   last averages and the mask; both queues come up empty
// - when pop stays low the result queue fills, the back end stops draining the
//   intake queue, and full rises once that queue holds two requests
module joystick_axis_moving_average_core #(
	parameter int unsigned WINDOW = jam_pkg::WINDOW_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	// sample requests
	input  logic               push,
	output logic               full,
	input  jam_pkg::in_item_t  samples,
	// averaged results
	input  logic               pop,
	output logic               empty,
	output jam_pkg::out_item_t result,
	// mirror mask register
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  jam_pkg::mask_t     cfg_data
);

	localparam int unsigned ITEM_W_L = jam_pkg::ITEM_W;
	localparam int unsigned RES_W_L  = $bits(jam_pkg::out_item_t);

	// front to intake queue
	logic              mid_wr_en;
	jam_pkg::in_item_t mid_wr_data;
	logic              mid_full;
	logic              mid_empty;
	logic              mid_rd_en;
	logic [ITEM_W_L-1:0] mid_rd_bits;
	logic [$clog2(jam_pkg::MID_DEPTH + 1)-1:0] mid_count;

	// back end to result queue
	logic                 res_wr_en;
	jam_pkg::out_item_t   res_wr_data;
	logic                 res_full;
	logic                 res_empty;
	logic [RES_W_L-1:0]   res_rd_bits;
	logic [jam_pkg::OUT_CNT_W-1:0] res_count;
	jam_pkg::out_status_t res_status;

	jam_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.samples   (samples),
		.q_full    (mid_full),
		.q_wr_en   (mid_wr_en),
		.q_wr_data (mid_wr_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// short decoupling queue between intake and the filter
	jam_fifo #(
		.DEPTH (jam_pkg::MID_DEPTH),
		.WIDTH (ITEM_W_L)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr_en),
		.wr_data (mid_wr_data),
		.rd_en   (mid_rd_en),
		.rd_data (mid_rd_bits),
		.full    (mid_full),
		.empty   (mid_empty),
		.count   (mid_count)
	);

	assign full = mid_full || (mid_count == '1 && 1'b0);

	jam_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (mid_empty),
		.q_rd_data   (jam_pkg::in_item_t'(mid_rd_bits)),
		.q_rd_en     (mid_rd_en),
		.res_status  (res_status),
		.res_wr_en   (res_wr_en),
		.res_wr_data (res_wr_data)
	);

	assign res_status.empty = res_empty;
	assign res_status.count = res_count;

	// result queue; the back end never writes it when full
	jam_fifo #(
		.DEPTH (jam_pkg::OUT_DEPTH),
		.WIDTH (RES_W_L)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr_en && !res_full),
		.wr_data (res_wr_data),
		.rd_en   (pop && !res_empty),
		.rd_data (res_rd_bits),
		.full    (res_full),
		.empty   (res_empty),
		.count   (res_count)
	);

	assign empty  = res_empty;
	assign result = jam_pkg::out_item_t'(res_rd_bits);

endmodule

/* design/jam_fifo.sv */
// small register queue with count, used between front and back and for results
module jam_fifo #(
	parameter int unsigned DEPTH = jam_pkg::MID_DEPTH,
	parameter int unsigned WIDTH = jam_pkg::ITEM_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_data = store_q[rd_ptr_q];
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;

endmodule

/* design/jam_front.sv */
// front end: request intake, mirror register and per-axis mirroring
module jam_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jam_pkg::in_item_t samples,
	input  logic             q_full,
	output logic             q_wr_en,
	output jam_pkg::in_item_t q_wr_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  jam_pkg::mask_t   cfg_data
);

	jam_pkg::mask_t    mask_q;
	jam_pkg::axis_vec_t raw;
	jam_pkg::axis_vec_t mirrored;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			mask_q <= cfg_data;
		end
	end

	assign raw = jam_pkg::axis_vec_t'(samples);

	always_comb begin
		for (int a = 0; a < jam_pkg::AXES; a++) begin
			mirrored[a] = mask_q[a] ? (jam_pkg::SAMPLE_MAX - raw[a]) : raw[a];
		end
	end

	assign q_wr_en   = push && !q_full;
	assign q_wr_data = jam_pkg::in_item_t'(mirrored);

endmodule

/* design/jam_back.sv */
// back end: sample ring, running sums, averaging and change detection
module jam_back #(
	parameter int unsigned WINDOW = jam_pkg::WINDOW_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  jam_pkg::in_item_t  q_rd_data,
	output logic               q_rd_en,
	input  jam_pkg::out_status_t res_status,
	output logic               res_wr_en,
	output jam_pkg::out_item_t res_wr_data
);

	localparam int unsigned IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned SUM_W    = $clog2(WINDOW * 4095 + 1);
	localparam int unsigned LOG_W    = $clog2(WINDOW);
	localparam int unsigned RECIP_SH = SUM_W + LOG_W;
	localparam int unsigned PROD_W   = 2 * SUM_W + 1;
	localparam int unsigned LOAD_W   = jam_pkg::OUT_CNT_W + 1;
	// ceil(2^sh / window): exact quotient for every sum that fits SUM_W bits
	localparam logic [SUM_W:0] RECIP_M =
		(SUM_W + 1)'(((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	typedef logic [SUM_W-1:0] sum_t;

	// ring memory, cleared logically by per-entry valid bits
	jam_pkg::in_item_t ring_mem [WINDOW];
	logic [WINDOW-1:0] valid_q;
	logic [IDX_W-1:0]  idx_q;

	sum_t sum_q [jam_pkg::AXES];
	jam_pkg::axis_vec_t last_q;

	logic               v_s1;
	logic [IDX_W-1:0]   slot_s1;
	jam_pkg::in_item_t  new_s1;
	jam_pkg::in_item_t  old_s1;

	logic v_s2;
	sum_t sum_s2 [jam_pkg::AXES];

	logic [LOAD_W-1:0]  load;
	logic               take;
	jam_pkg::axis_vec_t new_vec;
	jam_pkg::axis_vec_t old_vec;
	sum_t               sum_next [jam_pkg::AXES];
	logic [PROD_W-1:0]  prod [jam_pkg::AXES];
	jam_pkg::axis_vec_t avg;
	logic               changed;

	// results in flight plus queued must leave a free slot
	assign load = LOAD_W'(res_status.count) + LOAD_W'(v_s1) + LOAD_W'(v_s2);
	assign take = !q_empty && (load < LOAD_W'(jam_pkg::OUT_DEPTH));
	assign q_rd_en = take;

	// ring read with forwarding of the write in the same cycle
	always_ff @(posedge clk) begin
		if (v_s1) begin
			ring_mem[slot_s1] <= new_s1;
		end
		if (take) begin
			if (v_s1 && (slot_s1 == idx_q)) begin
				old_s1 <= new_s1;
			end else if (valid_q[idx_q]) begin
				old_s1 <= ring_mem[idx_q];
			end else begin
				old_s1 <= '0;
			end
			new_s1  <= q_rd_data;
			slot_s1 <= idx_q;
		end
	end

	assign new_vec = jam_pkg::axis_vec_t'(new_s1);
	assign old_vec = jam_pkg::axis_vec_t'(old_s1);

	always_comb begin
		for (int a = 0; a < jam_pkg::AXES; a++) begin
			sum_next[a] = sum_q[a] - SUM_W'(old_vec[a]) + SUM_W'(new_vec[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int a = 0; a < jam_pkg::AXES; a++) begin
				sum_s2[a] <= sum_next[a];
			end
		end
	end

	// divide by the window through a reciprocal multiply
	always_comb begin
		changed = 1'b0;
		for (int a = 0; a < jam_pkg::AXES; a++) begin
			prod[a] = PROD_W'(sum_s2[a]) * PROD_W'(RECIP_M);
			avg[a]  = jam_pkg::SAMPLE_W'(prod[a] >> RECIP_SH);
			if (avg[a] != last_q[a]) begin
				changed = 1'b1;
			end
		end
	end

	assign res_wr_en   = v_s2 && changed;
	assign res_wr_data = jam_pkg::out_item_t'(avg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			idx_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			last_q  <= '0;
			for (int a = 0; a < jam_pkg::AXES; a++) begin
				sum_q[a] <= '0;
			end
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			if (take) begin
				idx_q <= (idx_q == IDX_W'(WINDOW - 1)) ? '0 : idx_q + 1'b1;
			end
			if (v_s1) begin
				valid_q[slot_s1] <= 1'b1;
				for (int a = 0; a < jam_pkg::AXES; a++) begin
					sum_q[a] <= sum_next[a];
				end
			end
			if (res_wr_en) begin
				last_q <= avg;
			end
		end
	end

endmodule
